### hdl/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int unsigned FrontDepth  = 4;
  localparam int unsigned ResultDepth = 4;

  localparam int unsigned CpW  = 21;
  localparam int unsigned U16W = 16;
  localparam int unsigned LenW = 3;
  localparam int unsigned PayW = 7;

  localparam logic [CpW-1:0]  SurrFirst = 21'h00D800;
  localparam logic [CpW-1:0]  SurrLast  = 21'h00DFFF;
  localparam logic [CpW-1:0]  CodeMax   = 21'h10FFFF;
  localparam logic [CpW-1:0]  BmpMax    = 21'h00FFFF;
  localparam logic [CpW-1:0]  SuppBase  = 21'h010000;
  localparam logic [U16W-1:0] HiSurr    = 16'hD800;
  localparam logic [U16W-1:0] LoSurr    = 16'hDC00;

  typedef enum logic [2:0] {
    CLS_ASCII = 3'd0,
    CLS_CONT  = 3'd1,
    CLS_LEAD2 = 3'd2,
    CLS_LEAD3 = 3'd3,
    CLS_LEAD4 = 3'd4,
    CLS_BAD   = 3'd5
  } byte_class_e;

  typedef enum logic [0:0] {
    STATUS_OK  = 1'b0,
    STATUS_ERR = 1'b1
  } status_e;

  typedef struct packed {
    byte_class_e       cls;
    logic [PayW-1:0]   payload;
  } item_t;

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic [U16W-1:0]   utf16_first;
    logic [U16W-1:0]   utf16_second;
    logic [LenW-1:0]   bytes_used;
    status_e           status;
  } res_t;

endpackage

### hdl/u8sd_front.sv
// ----------------------------------------------------------------------------
// u8sd_front
// Accepts raw bytes, classifies each one and holds it in a short queue.
// ----------------------------------------------------------------------------
module u8sd_front #(
  parameter int unsigned Depth = u8sd_pkg::FrontDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  logic [7:0]      data_byte_i,
  output u8sd_pkg::item_t item_o,
  output logic            item_valid_o,
  input  logic            item_take_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u8sd_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;
  u8sd_pkg::item_t item_in;

  function automatic u8sd_pkg::item_t classify(input logic [7:0] b);
    u8sd_pkg::item_t it;
    it.payload = '0;
    if (!b[7]) begin
      it.cls     = u8sd_pkg::CLS_ASCII;
      it.payload = b[6:0];
    end else if (!b[6]) begin
      it.cls     = u8sd_pkg::CLS_CONT;
      it.payload = {1'b0, b[5:0]};
    end else if (!b[5]) begin
      it.cls     = u8sd_pkg::CLS_LEAD2;
      it.payload = {2'b0, b[4:0]};
    end else if (!b[4]) begin
      it.cls     = u8sd_pkg::CLS_LEAD3;
      it.payload = {3'b0, b[3:0]};
    end else if (!b[3]) begin
      it.cls     = u8sd_pkg::CLS_LEAD4;
      it.payload = {4'b0, b[2:0]};
    end else begin
      it.cls     = u8sd_pkg::CLS_BAD;
    end
    return it;
  endfunction

  assign item_in      = classify(data_byte_i);
  assign full_o       = (count_q == CntW'(Depth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_take_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

### hdl/u8sd_back.sv
// ----------------------------------------------------------------------------
// u8sd_back
// Assembles code points from classified bytes, converts them to UTF-16 and
// queues the results.
// ----------------------------------------------------------------------------
module u8sd_back #(
  parameter int unsigned Depth = u8sd_pkg::ResultDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  u8sd_pkg::item_t item_i,
  input  logic            item_valid_i,
  output logic            item_take_o,
  output u8sd_pkg::res_t  res_o,
  output logic            empty_o,
  input  logic            pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_NEED1 = 4'b0010,
    ST_NEED2 = 4'b0100,
    ST_NEED3 = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic [u8sd_pkg::CpW-1:0]      partial_q, partial_d;
  logic [u8sd_pkg::LenW-1:0]     seq_len_q, seq_len_d;
  logic [u8sd_pkg::CpW-1:0]      shifted;
  logic                          res_push;
  u8sd_pkg::res_t                res_d;

  u8sd_pkg::res_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            res_full;
  logic            do_pop;

  function automatic u8sd_pkg::res_t error_res();
    u8sd_pkg::res_t r;
    r        = '0;
    r.status = u8sd_pkg::STATUS_ERR;
    return r;
  endfunction

  function automatic u8sd_pkg::res_t make_char(input logic [u8sd_pkg::CpW-1:0] cp,
                                               input logic [u8sd_pkg::LenW-1:0] len);
    u8sd_pkg::res_t           r;
    logic [u8sd_pkg::CpW-1:0] u;
    u = cp - u8sd_pkg::SuppBase;
    if ((cp >= u8sd_pkg::SurrFirst && cp <= u8sd_pkg::SurrLast) || cp > u8sd_pkg::CodeMax) begin
      r = error_res();
    end else begin
      r.code_point = cp;
      r.bytes_used = len;
      r.status     = u8sd_pkg::STATUS_OK;
      if (cp <= u8sd_pkg::BmpMax) begin
        r.utf16_first  = cp[15:0];
        r.utf16_second = '0;
      end else begin
        r.utf16_first  = u8sd_pkg::HiSurr + {6'b0, u[19:10]};
        r.utf16_second = u8sd_pkg::LoSurr + {6'b0, u[9:0]};
      end
    end
    return r;
  endfunction

  assign res_full    = (count_q == CntW'(Depth));
  assign item_take_o = item_valid_i && !res_full;
  assign shifted     = {partial_q[14:0], item_i.payload[5:0]};

  always_comb begin
    state_d   = state_q;
    partial_d = partial_q;
    seq_len_d = seq_len_q;
    res_push  = 1'b0;
    res_d     = error_res();
    if (item_take_o) begin
      case (state_q)
        ST_IDLE: begin
          case (item_i.cls)
            u8sd_pkg::CLS_ASCII: begin
              res_push = 1'b1;
              res_d    = make_char({14'b0, item_i.payload}, 3'd1);
            end
            u8sd_pkg::CLS_LEAD2: begin
              partial_d = {16'b0, item_i.payload[4:0]};
              seq_len_d = 3'd2;
              state_d   = ST_NEED1;
            end
            u8sd_pkg::CLS_LEAD3: begin
              partial_d = {17'b0, item_i.payload[3:0]};
              seq_len_d = 3'd3;
              state_d   = ST_NEED2;
            end
            u8sd_pkg::CLS_LEAD4: begin
              partial_d = {18'b0, item_i.payload[2:0]};
              seq_len_d = 3'd4;
              state_d   = ST_NEED3;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
        ST_NEED1: begin
          res_push = 1'b1;
          state_d  = ST_IDLE;
          if (item_i.cls == u8sd_pkg::CLS_CONT) begin
            res_d = make_char(shifted, seq_len_q);
          end
        end
        ST_NEED2: begin
          if (item_i.cls == u8sd_pkg::CLS_CONT) begin
            partial_d = shifted;
            state_d   = ST_NEED1;
          end else begin
            res_push = 1'b1;
            state_d  = ST_IDLE;
          end
        end
        ST_NEED3: begin
          if (item_i.cls == u8sd_pkg::CLS_CONT) begin
            partial_d = shifted;
            state_d   = ST_NEED2;
          end else begin
            res_push = 1'b1;
            state_d  = ST_IDLE;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  assign empty_o = (count_q == '0);
  assign res_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (res_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({res_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      partial_q <= '0;
      seq_len_q <= '0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      count_q   <= '0;
    end else begin
      state_q   <= state_d;
      partial_q <= partial_d;
      seq_len_q <= seq_len_d;
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      mem_q[wr_ptr_q] <= res_d;
    end
  end

endmodule

### hdl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder with code point and UTF-16 results.
// ----------------------------------------------------------------------------
// The decoder takes one UTF-8 byte per cycle and sustains that rate as long
// as results are popped. A byte is classified and written into the input
// queue on the cycle it is pushed; the decode stage takes it no earlier than
// the next cycle and updates its sequence state, so a result is written into
// the result queue at the clock edge that accepts its last byte. Lead bytes
// yield no result. Malformed input yields one result with status set and all
// other fields zero, and the decoder returns to idle. The depths of both
// queues are set by FrontDepth and ResultDepth and must be at least two.
module utf8_stream_decoder #(
  parameter int unsigned FrontDepth  = u8sd_pkg::FrontDepth,
  parameter int unsigned ResultDepth = u8sd_pkg::ResultDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    data_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [u8sd_pkg::CpW-1:0]      code_point_o,
  output logic [u8sd_pkg::U16W-1:0]     utf16_first_o,
  output logic [u8sd_pkg::U16W-1:0]     utf16_second_o,
  output logic [u8sd_pkg::LenW-1:0]     bytes_used_o,
  output logic                          status_o
);

  u8sd_pkg::item_t item;
  logic            item_valid;
  logic            item_take;
  u8sd_pkg::res_t  res;

  u8sd_front #(
    .Depth(FrontDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .data_byte_i (data_byte_i),
    .item_o      (item),
    .item_valid_o(item_valid),
    .item_take_i (item_take)
  );

  u8sd_back #(
    .Depth(ResultDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_valid_i(item_valid),
    .item_take_o (item_take),
    .res_o       (res),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign code_point_o   = res.code_point;
  assign utf16_first_o  = res.utf16_first;
  assign utf16_second_o = res.utf16_second;
  assign bytes_used_o   = res.bytes_used;
  assign status_o       = res.status;

endmodule

### verif/tb_utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder
// Self-checking testbench for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
// A driver feeds bytes from a queue and a monitor pops results. A predictor
// decodes every accepted byte and keeps the expected characters in a queue.
// Each popped result is compared with the oldest one, field by field. A short
// directed list comes first, then random well-formed sequences mixed with
// noise and broken sequences. Both sides idle at random. The receiver holds
// off once for a long time, and the sender waits for the decoder to drain
// after each phase.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] AsciiMax = 8'h7F;
  localparam logic [7:0] ContMin  = 8'h80;
  localparam logic [7:0] ContMax  = 8'hBF;
  localparam logic [7:0] Lead2Max = 8'hDF;
  localparam logic [7:0] Lead3Max = 8'hEF;
  localparam logic [7:0] Lead4Max = 8'hF7;
  localparam logic [7:0] Lead2    = 8'hC0;
  localparam logic [7:0] Lead3    = 8'hE0;
  localparam logic [7:0] Lead4    = 8'hF0;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned HoldAfter  = 150;
  localparam int unsigned CalmBytes  = 100;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           push        = 1'b0;
  logic                           full;
  logic [7:0]                     data_byte_i = 8'h00;
  logic                           empty;
  logic                           pop         = 1'b0;
  logic [u8sd_pkg::CpW-1:0]       code_point_o;
  logic [u8sd_pkg::U16W-1:0]      utf16_first_o;
  logic [u8sd_pkg::U16W-1:0]      utf16_second_o;
  logic [u8sd_pkg::LenW-1:0]      bytes_used_o;
  logic                           status_o;

  logic [7:0]                     byte_q[$];
  u8sd_pkg::res_t                 char_q[$];

  logic [1:0]                     pend_cnt  = '0;
  logic [u8sd_pkg::CpW-1:0]       part_cp   = '0;
  logic [u8sd_pkg::LenW-1:0]      seq_len   = '0;

  int unsigned      mismatches = 0;
  int unsigned      bytes_in   = 0;
  int unsigned      tx_gap     = 0;
  int unsigned      rx_gap     = 0;
  int unsigned      rx_hold    = 0;
  bit               tx_taken   = 1'b0;
  bit               held_once  = 1'b0;
  bit               all_queued = 1'b0;
  bit               calm;

  assign calm = all_queued && (byte_q.size() < CalmBytes);

  utf8_stream_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .empty          (empty),
    .pop            (pop),
    .code_point_o   (code_point_o),
    .utf16_first_o  (utf16_first_o),
    .utf16_second_o (utf16_second_o),
    .bytes_used_o   (bytes_used_o),
    .status_o       (status_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit finish_char(input logic [u8sd_pkg::CpW-1:0] cp,
                                     input logic [u8sd_pkg::LenW-1:0] len,
                                     output u8sd_pkg::res_t r);
    logic [u8sd_pkg::CpW-1:0] ofs;
    r        = '0;
    pend_cnt = '0;
    part_cp  = '0;
    seq_len  = '0;
    if ((cp >= u8sd_pkg::SurrFirst && cp <= u8sd_pkg::SurrLast) ||
        cp > u8sd_pkg::CodeMax) begin
      r.status = u8sd_pkg::STATUS_ERR;
    end else if (cp <= u8sd_pkg::BmpMax) begin
      r.code_point  = cp;
      r.utf16_first = cp[u8sd_pkg::U16W-1:0];
      r.bytes_used  = len;
      r.status      = u8sd_pkg::STATUS_OK;
    end else begin
      ofs            = cp - u8sd_pkg::SuppBase;
      r.code_point   = cp;
      r.utf16_first  = u8sd_pkg::HiSurr + u8sd_pkg::U16W'(ofs[19:10]);
      r.utf16_second = u8sd_pkg::LoSurr + u8sd_pkg::U16W'(ofs[9:0]);
      r.bytes_used   = len;
      r.status       = u8sd_pkg::STATUS_OK;
    end
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output u8sd_pkg::res_t r);
    r = '0;
    if (pend_cnt == 2'd0) begin
      if (b <= AsciiMax) begin
        return finish_char(u8sd_pkg::CpW'(b), u8sd_pkg::LenW'(1), r);
      end else if (b <= ContMax || b > Lead4Max) begin
        return finish_char(u8sd_pkg::CodeMax + 1'b1, '0, r);
      end else if (b <= Lead2Max) begin
        part_cp  = u8sd_pkg::CpW'(b[4:0]);
        pend_cnt = 2'd1;
        seq_len  = u8sd_pkg::LenW'(2);
      end else if (b <= Lead3Max) begin
        part_cp  = u8sd_pkg::CpW'(b[3:0]);
        pend_cnt = 2'd2;
        seq_len  = u8sd_pkg::LenW'(3);
      end else begin
        part_cp  = u8sd_pkg::CpW'(b[2:0]);
        pend_cnt = 2'd3;
        seq_len  = u8sd_pkg::LenW'(4);
      end
      return 1'b0;
    end
    if (b < ContMin || b > ContMax) begin
      return finish_char(u8sd_pkg::CodeMax + 1'b1, '0, r);
    end
    part_cp  = {part_cp[u8sd_pkg::CpW-7:0], b[5:0]};
    pend_cnt = pend_cnt - 2'd1;
    if (pend_cnt == 2'd0) begin
      return finish_char(part_cp, seq_len, r);
    end
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Driver: a byte stays on the bus until it is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (push && !tx_taken) begin
    end else if (tx_gap > 0) begin
      tx_gap--;
      push <= 1'b0;
    end else if (byte_q.size() == 0) begin
      push <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      tx_gap = $urandom_range(0, 5);
      push <= 1'b0;
    end else begin
      push        <= 1'b1;
      data_byte_i <= byte_q[0];
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (!held_once && bytes_in >= HoldAfter) begin
      held_once = 1'b1;
      rx_hold   = HoldCycles;
      pop <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      pop <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 5);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Monitor: predict on each accepted byte, check each accepted result.
  always @(posedge clk_i) begin
    u8sd_pkg::res_t exp_r;
    u8sd_pkg::res_t new_r;
    tx_taken = push && !full;
    if (rst_ni && tx_taken) begin
      bytes_in++;
      void'(byte_q.pop_front());
      if (decode_byte(data_byte_i, new_r)) begin
        char_q.push_back(new_r);
      end
    end
    if (rst_ni && pop && !empty) begin
      if (char_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual cp %0h status %0b",
                 $time, code_point_o, status_o);
      end else begin
        exp_r = char_q.pop_front();
        check_field("code_point", 32'(exp_r.code_point), 32'(code_point_o));
        check_field("utf16_first", 32'(exp_r.utf16_first), 32'(utf16_first_o));
        check_field("utf16_second", 32'(exp_r.utf16_second), 32'(utf16_second_o));
        check_field("bytes_used", 32'(exp_r.bytes_used), 32'(bytes_used_o));
        check_field("status", 32'(exp_r.status), 32'(status_o));
      end
    end
  end

  task automatic wait_drained();
    while (byte_q.size() != 0 || char_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic [7:0] cont_byte();
    return ContMin | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] lead_byte(input int unsigned len);
    case (len)
      1:       return 8'($urandom_range(0, 127));
      2:       return Lead2 | 8'($urandom_range(0, 31));
      3:       return Lead3 | 8'($urandom_range(0, 15));
      default: return Lead4 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  // Mostly well-formed sequences, some noise bytes and cut-off sequences.
  task automatic fill_random(input int unsigned count);
    int unsigned added;
    int unsigned len;
    int unsigned cut;
    int unsigned kind;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 4);
      if (kind == 0) begin
        byte_q.push_back(8'($urandom_range(0, 255)));
        added++;
      end else if (kind == 1 && len > 1) begin
        cut = $urandom_range(1, len - 1);
        byte_q.push_back(lead_byte(len));
        for (int i = 1; i < cut; i++) begin
          byte_q.push_back(cont_byte());
        end
        if ($urandom_range(0, 1) == 0) begin
          byte_q.push_back(8'($urandom_range(0, 127)));
        end else begin
          byte_q.push_back(8'($urandom_range(192, 255)));
        end
        added += cut + 1;
      end else begin
        byte_q.push_back(lead_byte(len));
        for (int i = 1; i < len; i++) begin
          byte_q.push_back(cont_byte());
        end
        added += len;
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // ASCII extremes, stray continuation, invalid lead, overlong, largest
    // two-byte value, surrogate, largest scalar, too large, bad continuation.
    byte_q = '{8'h00, 8'h7F, 8'h80, 8'hFF,
               8'hC0, 8'h80,
               8'hDF, 8'hBF,
               8'hED, 8'hA0, 8'h80,
               8'hF4, 8'h8F, 8'hBF, 8'hBF,
               8'hF7, 8'hBF, 8'hBF, 8'hBF,
               8'hE1, 8'hC3,
               8'hC2, 8'h41};
    wait_drained();
    repeat ($urandom_range(5, 20)) @(posedge clk_i);

    fill_random(220);
    wait_drained();
    repeat ($urandom_range(5, 20)) @(posedge clk_i);

    fill_random(230);
    all_queued = 1'b1;
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && char_q.size() == 0) begin
      $display("utf8_stream_decoder regression: pass");
    end else begin
      $display("utf8_stream_decoder regression: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("utf8_stream_decoder regression: fail");
    $finish;
  end

endmodule
